FILE: sv/dpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared constants, state type and modular add for the DAG path counter.
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int NODE_W          = 11;
    localparam int PATH_W          = 30;
    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_MAX_EDGES   = 4096;
    localparam logic [PATH_W-1:0] PATH_MOD = 30'd1000000007;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP,
        S_POP_WAIT,
        S_OUT_HEAD,
        S_OUT_EDGE,
        S_OUT_DEG,
        S_IN_HEAD,
        S_IN_EDGE,
        S_IN_PATH,
        S_FIN_WAIT,
        S_RESULT
    } dpc_state_t;

    // both operands below the modulus
    function automatic logic [PATH_W-1:0] add_mod(input logic [PATH_W-1:0] a,
                                                  input logic [PATH_W-1:0] b);
        logic [PATH_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, PATH_MOD})
            begin
                s = s - {1'b0, PATH_MOD};
            end
            add_mod = s[PATH_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/dpc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpc_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/dag_path_count_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dag_path_count_mod
// Counts paths from node 1 to the last node of a loaded DAG, mod 1e9+7.
// ----------------------------------------------------------------------------
// Edges come in one per item and are linked into forward and backward lists
// held in on-chip RAMs; each edge is a head read, then a linked write. The
// item marked last starts Kahn's order: an in-degree scan of each node, then
// per dequeued node a pop, out-head and in-head reads, an edge read and degree
// update per outgoing edge and an edge read and path add per incoming edge,
// all paced by the single read port of each RAM. After the result is latched,
// a clearing pass of MAX_NODES entries resets heads, in-degrees and path
// counts; the same pass runs after reset. Input is stalled outside S_IDLE.
// ----------------------------------------------------------------------------
module dag_path_count_mod
    import dpc_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [NODE_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [NODE_W-1:0] edge_from,
    input  wire logic [NODE_W-1:0] edge_to,
    input  wire logic              has_edge,
    input  wire logic              last,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [PATH_W-1:0]      path_count,
    output logic                   input_dropped
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1) > 0 ? $clog2(MAX_EDGES + 1) : 1;
    localparam int HW  = EW + 1;
    localparam int EDW = 2 * NW + 2 * HW;
    // edge word: {in_next, out_next, dst, src}
    localparam int SRC_LO = 0;
    localparam int DST_LO = NW;
    localparam int ON_LO  = 2 * NW;
    localparam int IN_LO  = 2 * NW + HW;
    localparam logic [HW-1:0] EMPTY = HW'(MAX_EDGES);

    dpc_state_t state_reg, state_next;

    logic [NODE_W-1:0] node_count_reg;
    logic [NCW-1:0]    cnt_reg, cnt_next;
    logic [NW-1:0]     u_reg, u_next;
    logic [NW-1:0]     v_reg, v_next;
    logic [HW-1:0]     e_reg, e_next;
    logic [PATH_W-1:0] acc_reg, acc_next;
    logic [NCW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NCW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ECW-1:0]    edges_reg, edges_next;
    logic              dropped_reg, dropped_next;
    logic [NW-1:0]     ld_from_reg, ld_from_next;
    logic [NW-1:0]     ld_to_reg, ld_to_next;
    logic              ld_last_reg, ld_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [PATH_W-1:0] out_path_reg, out_path_next;
    logic              out_drop_reg, out_drop_next;

    // RAM ports
    logic            edg_we;
    logic [EW-1:0]   edg_waddr, edg_raddr;
    logic [EDW-1:0]  edg_wdata, edg_rdata;
    logic            oh_we;
    logic [NW-1:0]   oh_waddr, oh_raddr;
    logic [HW-1:0]   oh_wdata, oh_rdata;
    logic            ih_we;
    logic [NW-1:0]   ih_waddr, ih_raddr;
    logic [HW-1:0]   ih_wdata, ih_rdata;
    logic            deg_we;
    logic [NW-1:0]   deg_waddr, deg_raddr;
    logic [HW-1:0]   deg_wdata, deg_rdata;
    logic            pth_we;
    logic [NW-1:0]   pth_waddr, pth_raddr;
    logic [PATH_W-1:0] pth_wdata, pth_rdata;
    logic            q_we;
    logic [NW-1:0]   q_waddr, q_raddr;
    logic [NW-1:0]   q_wdata, q_rdata;

    logic [NCW-1:0]  n_eff;
    logic            in_acc;
    logic            out_acc;
    logic            edge_ok;
    logic            edge_full;
    logic [NW-1:0]   from_idx, to_idx;
    logic [PATH_W-1:0] acc_sum;
    logic            q_room;
    logic            scan_end;
    logic            pushed_deg;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = NCW'(1);
        end
        else if (32'(node_count_reg) > 32'(MAX_NODES))
        begin
            n_eff = NCW'(MAX_NODES);
        end
        else
        begin
            n_eff = NCW'(node_count_reg);
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign edge_full = (32'(edges_reg) >= 32'(MAX_EDGES));
    assign edge_ok   = has_edge && (edge_from != '0) && (edge_to != '0)
                       && (32'(edge_from) <= 32'(n_eff))
                       && (32'(edge_to) <= 32'(n_eff)) && !edge_full;
    assign from_idx  = NW'(edge_from - NODE_W'(1));
    assign to_idx    = NW'(edge_to - NODE_W'(1));
    assign acc_sum   = add_mod(acc_reg, pth_rdata);
    assign q_room    = (32'(wr_ptr_reg) < 32'(MAX_NODES));
    assign scan_end  = ((cnt_reg + NCW'(1)) == n_eff);
    assign pushed_deg = (deg_rdata == HW'(1));

    assign out_valid     = out_valid_reg;
    assign path_count    = out_path_reg;
    assign input_dropped = out_drop_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (cnt_reg == NCW'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (edge_ok)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (last)
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_LOAD:     state_next = ld_last_reg ? S_SCAN_RD : S_IDLE;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK: state_next = scan_end ? S_POP : S_SCAN_RD;
            S_POP:      state_next = (rd_ptr_reg < wr_ptr_reg) ? S_POP_WAIT : S_FIN_WAIT;
            S_POP_WAIT: state_next = S_OUT_HEAD;
            S_OUT_HEAD: state_next = (oh_rdata == EMPTY) ? S_IN_HEAD : S_OUT_EDGE;
            S_OUT_EDGE: state_next = S_OUT_DEG;
            S_OUT_DEG:  state_next = (e_reg == EMPTY) ? S_IN_HEAD : S_OUT_EDGE;
            S_IN_HEAD:  state_next = (ih_rdata == EMPTY) ? S_POP : S_IN_EDGE;
            S_IN_EDGE:  state_next = S_IN_PATH;
            S_IN_PATH:  state_next = (e_reg == EMPTY) ? S_POP : S_IN_EDGE;
            S_FIN_WAIT: state_next = S_RESULT;
            S_RESULT:
            begin
                if (!out_valid_reg || out_acc)
                begin
                    state_next = S_CLEAR;
                end
            end
            default:    state_next = S_CLEAR;
        endcase
    end

    // RAM controls
    always_comb
    begin
        edg_we    = 1'b0;
        edg_waddr = edges_reg[EW-1:0];
        edg_wdata = {ih_rdata, oh_rdata, ld_to_reg, ld_from_reg};
        edg_raddr = e_reg[EW-1:0];
        oh_we     = 1'b0;
        oh_waddr  = ld_from_reg;
        oh_wdata  = HW'(edges_reg);
        oh_raddr  = from_idx;
        ih_we     = 1'b0;
        ih_waddr  = ld_to_reg;
        ih_wdata  = HW'(edges_reg);
        ih_raddr  = to_idx;
        deg_we    = 1'b0;
        deg_waddr = ld_to_reg;
        deg_wdata = deg_rdata + HW'(1);
        deg_raddr = to_idx;
        pth_we    = 1'b0;
        pth_waddr = u_reg;
        pth_wdata = acc_reg;
        pth_raddr = edg_rdata[SRC_LO +: NW];
        q_we      = 1'b0;
        q_waddr   = wr_ptr_reg[NW-1:0];
        q_wdata   = v_reg;
        q_raddr   = rd_ptr_reg[NW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                oh_we     = 1'b1;
                oh_waddr  = cnt_reg[NW-1:0];
                oh_wdata  = EMPTY;
                ih_we     = 1'b1;
                ih_waddr  = cnt_reg[NW-1:0];
                ih_wdata  = EMPTY;
                deg_we    = 1'b1;
                deg_waddr = cnt_reg[NW-1:0];
                deg_wdata = '0;
                pth_we    = 1'b1;
                pth_waddr = cnt_reg[NW-1:0];
                pth_wdata = '0;
            end
            S_LOAD:
            begin
                edg_we = 1'b1;
                oh_we  = 1'b1;
                ih_we  = 1'b1;
                deg_we = 1'b1;
            end
            S_SCAN_RD:
            begin
                deg_raddr = cnt_reg[NW-1:0];
                pth_we    = 1'b1;
                pth_waddr = '0;
                pth_wdata = PATH_W'(1);
            end
            S_SCAN_CHK:
            begin
                q_we    = (deg_rdata == '0) && q_room;
                q_wdata = cnt_reg[NW-1:0];
            end
            S_POP:
            begin
                pth_raddr = NW'(n_eff - NCW'(1));
            end
            S_POP_WAIT:
            begin
                oh_raddr = q_rdata;
            end
            S_OUT_HEAD:
            begin
                edg_raddr = oh_rdata[EW-1:0];
                ih_raddr  = u_reg;
            end
            S_OUT_EDGE:
            begin
                deg_raddr = edg_rdata[DST_LO +: NW];
            end
            S_OUT_DEG:
            begin
                ih_raddr  = u_reg;
                deg_waddr = v_reg;
                deg_wdata = deg_rdata - HW'(1);
                deg_we    = (deg_rdata != '0);
                q_we      = pushed_deg && q_room;
            end
            S_IN_HEAD:
            begin
                edg_raddr = ih_rdata[EW-1:0];
                pth_we    = (ih_rdata == EMPTY);
            end
            S_IN_PATH:
            begin
                pth_wdata = acc_sum;
                pth_we    = (e_reg == EMPTY);
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        cnt_next       = cnt_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        edges_next     = edges_reg;
        dropped_next   = dropped_reg;
        ld_from_next   = ld_from_reg;
        ld_to_next     = ld_to_reg;
        ld_last_next   = ld_last_reg;
        out_valid_next = out_valid_reg && !out_acc;
        out_path_next  = out_path_reg;
        out_drop_next  = out_drop_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_next     = cnt_reg + NCW'(1);
                edges_next   = '0;
                dropped_next = 1'b0;
                rd_ptr_next  = '0;
                wr_ptr_next  = '0;
            end
            S_IDLE:
            begin
                cnt_next     = '0;
                ld_from_next = from_idx;
                ld_to_next   = to_idx;
                ld_last_next = last;
                if (in_acc && has_edge && !edge_ok)
                begin
                    dropped_next = 1'b1;
                end
            end
            S_LOAD:
            begin
                edges_next = edges_reg + ECW'(1);
            end
            S_SCAN_CHK:
            begin
                cnt_next = cnt_reg + NCW'(1);
                if ((deg_rdata == '0) && q_room)
                begin
                    wr_ptr_next = wr_ptr_reg + NCW'(1);
                end
            end
            S_POP:
            begin
                if (rd_ptr_reg < wr_ptr_reg)
                begin
                    rd_ptr_next = rd_ptr_reg + NCW'(1);
                end
            end
            S_POP_WAIT:
            begin
                u_next   = q_rdata;
                acc_next = (q_rdata == '0) ? PATH_W'(1) : '0;
            end
            S_OUT_EDGE:
            begin
                v_next = edg_rdata[DST_LO +: NW];
                e_next = edg_rdata[ON_LO +: HW];
            end
            S_OUT_DEG:
            begin
                if (pushed_deg && q_room)
                begin
                    wr_ptr_next = wr_ptr_reg + NCW'(1);
                end
            end
            S_IN_EDGE:
            begin
                e_next = edg_rdata[IN_LO +: HW];
            end
            S_IN_PATH:
            begin
                acc_next = acc_sum;
            end
            S_FIN_WAIT:
            begin
                acc_next = pth_rdata;
            end
            S_RESULT:
            begin
                cnt_next = '0;
                if (!out_valid_reg || out_acc)
                begin
                    out_valid_next = 1'b1;
                    out_path_next  = acc_reg;
                    out_drop_next  = dropped_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_OUT_HEAD)
        begin
            e_next = oh_rdata;
        end
        else if (state_reg == S_IN_HEAD)
        begin
            e_next = ih_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            node_count_reg <= NODE_W'(1);
            cnt_reg        <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            edges_reg      <= '0;
            dropped_reg    <= 1'b0;
            ld_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
            cnt_reg       <= cnt_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            edges_reg     <= edges_next;
            dropped_reg   <= dropped_next;
            ld_last_reg   <= ld_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        e_reg        <= e_next;
        acc_reg      <= acc_next;
        ld_from_reg  <= ld_from_next;
        ld_to_reg    <= ld_to_next;
        out_path_reg <= out_path_next;
        out_drop_reg <= out_drop_next;
    end

    dpc_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edg_we), .waddr(edg_waddr), .wdata(edg_wdata),
        .raddr(edg_raddr), .rdata(edg_rdata)
    );

    dpc_ram #(.WIDTH(HW), .DEPTH(MAX_NODES)) u_out_head_ram (
        .clk(clk), .we(oh_we), .waddr(oh_waddr), .wdata(oh_wdata),
        .raddr(oh_raddr), .rdata(oh_rdata)
    );

    dpc_ram #(.WIDTH(HW), .DEPTH(MAX_NODES)) u_in_head_ram (
        .clk(clk), .we(ih_we), .waddr(ih_waddr), .wdata(ih_wdata),
        .raddr(ih_raddr), .rdata(ih_rdata)
    );

    dpc_ram #(.WIDTH(HW), .DEPTH(MAX_NODES)) u_degree_ram (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );

    dpc_ram #(.WIDTH(PATH_W), .DEPTH(MAX_NODES)) u_paths_ram (
        .clk(clk), .we(pth_we), .waddr(pth_waddr), .wdata(pth_wdata),
        .raddr(pth_raddr), .rdata(pth_rdata)
    );

    dpc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

endmodule
`default_nettype wire
